@@ sv/dpm_pkg.sv @@
// dpm_pkg: shared types, constants and the log table generator for the
// dew point pipeline. No dependencies.
package dpm_pkg;

  localparam int TEMP_W = 14;
  localparam int HUM_W  = 14;

  localparam int LOG_TABLE_ENTRIES_DEF = 256;

  localparam int FRAC_BITS = 20;  // mantissa fraction, Q20
  localparam int ROM_W     = 16;  // ln(1+x) samples, Q16
  localparam int LN_W      = 22;  // ln(h/10000) in Q16, signed

  localparam logic signed [TEMP_W-1:0] T_MIN = -14'sd4000;
  localparam logic signed [TEMP_W-1:0] T_MAX = 14'sd5000;
  localparam logic [HUM_W-1:0]         H_MIN = 14'd10;
  localparam logic [HUM_W-1:0]         H_MAX = 14'd10000;

  localparam int LN2_Q16     = 45426;
  localparam int LN10000_Q16 = 603609;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
  } dpm_in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] dewpt;
    logic                     valid_res;
  } dpm_res_t;

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/n) in Q16 by an atanh series in Q30
  function automatic logic [ROM_W-1:0] log_rom_entry(input int unsigned i,
                                                     input int unsigned n);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] pw;
    logic [63:0] sum;
    logic [63:0] res;
    z   = udiv64(64'(i) << 30, 64'(2 * n + i));
    z2  = (z * z) >> 30;
    pw  = z;
    sum = '0;
    for (int k = 0; k < 25; k++) begin
      sum = sum + udiv64(pw, 64'(2 * k + 1));
      pw  = (pw * z2) >> 30;
    end
    res = (64'd2 * sum + 64'd8192) >> 14;
    return res[ROM_W-1:0];
  endfunction

endpackage

@@ sv/dpm_div.sv @@
// dpm_div: pipelined restoring divider, one quotient bit per stage, with a
// tag carried alongside. Depends on nothing.
module dpm_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 22,
  parameter int Q_W   = 18,
  parameter int TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             valid_q [Q_W];
  logic [NUM_W-1:0] rem_q   [Q_W];
  logic [DEN_W-1:0] den_q   [Q_W];
  logic [Q_W-1:0]   quo_q   [Q_W];
  logic [TAG_W-1:0] tag_q   [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic             valid_in;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [TAG_W-1:0] tag_in;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] den_sh;
    logic [NUM_W-1:0] rem_d;
    logic [Q_W-1:0]   quo_d;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = num_i;
      assign den_in   = den_i;
      assign quo_in   = '0;
      assign tag_in   = tag_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign den_in   = den_q[s-1];
      assign quo_in   = quo_q[s-1];
      assign tag_in   = tag_q[s-1];
    end

    always_comb begin
      rem_ext = CMP_W'(rem_in);
      den_sh  = CMP_W'(den_in) << (Q_W - 1 - s);
      rem_d   = rem_in;
      quo_d   = quo_in;
      if (rem_ext >= den_sh) begin
        rem_d = NUM_W'(rem_ext - den_sh);
        quo_d[Q_W-1-s] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      den_q[s] <= den_in;
      quo_q[s] <= quo_d;
      tag_q[s] <= tag_in;
    end
  end

  assign valid_o = valid_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];

endmodule

@@ sv/dpm_ln.sv @@
// dpm_ln: five-stage pipeline for ln(h/10000) in Q16 from a normalized
// mantissa and an interpolated log table. Depends on dpm_pkg.
module dpm_ln
  import dpm_pkg::*;
#(
  parameter int LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF,
  parameter int TAG_W             = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [HUM_W-1:0]       hum_i,
  input  logic [TAG_W-1:0]       tag_i,
  output logic                   valid_o,
  output logic signed [LN_W-1:0] ln_o,
  output logic [TAG_W-1:0]       tag_o
);

  localparam int N     = LOG_TABLE_ENTRIES;
  localparam int IDX_W = $clog2(N);
  localparam int NB    = $clog2(N + 1);
  localparam int POS_W = FRAC_BITS + NB;
  localparam int PRD_W = ROM_W + FRAC_BITS;
  localparam int E_W   = 4;

  typedef logic [ROM_W-1:0] rom_arr_t [N];

  function automatic rom_arr_t build_rom(input int unsigned off);
    rom_arr_t r;
    for (int i = 0; i < N; i++) begin
      r[i] = log_rom_entry(i + off, N);
    end
    return r;
  endfunction

  localparam rom_arr_t RomLo = build_rom(0);
  localparam rom_arr_t RomHi = build_rom(1);

  logic [4:0]       valid_q;
  logic [TAG_W-1:0] tag_q [5];

  // stage 1: leading one and normalize
  logic [E_W-1:0]             e1_d;
  logic [HUM_W+FRAC_BITS-1:0] mant;
  logic [E_W-1:0]             e1_q;
  logic [FRAC_BITS-1:0]       f1_q;

  always_comb begin
    e1_d = '0;
    for (int j = 1; j < HUM_W; j++) begin
      if (hum_i[j]) e1_d = E_W'(j);
    end
    mant = {hum_i, {FRAC_BITS{1'b0}}} >> e1_d;
  end

  // stage 2: table position
  logic [POS_W-1:0]     pos;
  logic [NB-1:0]        idx_raw;
  logic [IDX_W-1:0]     idx2_d;
  logic [E_W-1:0]       e2_q;
  logic [IDX_W-1:0]     idx2_q;
  logic [FRAC_BITS-1:0] rem2_q;

  always_comb begin
    pos     = POS_W'(f1_q) * POS_W'(N);
    idx_raw = pos[POS_W-1:FRAC_BITS];
    if (idx_raw >= NB'(N)) begin
      idx2_d = IDX_W'(N - 1);
    end else begin
      idx2_d = idx_raw[IDX_W-1:0];
    end
  end

  // stage 3: table read
  logic [E_W-1:0]       e3_q;
  logic [ROM_W-1:0]     lo3_q;
  logic [ROM_W-1:0]     diff3_q;
  logic [FRAC_BITS-1:0] rem3_q;

  // stage 4: interpolation
  logic [PRD_W-1:0] prod;
  logic [E_W-1:0]   e4_q;
  logic [ROM_W-1:0] lo4_q;
  logic [ROM_W-1:0] interp4_q;

  assign prod = PRD_W'(diff3_q) * PRD_W'(rem3_q) + (PRD_W'(1) << (FRAC_BITS - 1));

  // stage 5: add exponent and scale
  logic [LN_W-1:0]        ln_sum;
  logic signed [LN_W-1:0] ln5_q;

  assign ln_sum = LN_W'(e4_q) * LN_W'(LN2_Q16) + LN_W'(lo4_q) + LN_W'(interp4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0]  <= tag_i;
    tag_q[1]  <= tag_q[0];
    tag_q[2]  <= tag_q[1];
    tag_q[3]  <= tag_q[2];
    tag_q[4]  <= tag_q[3];
    e1_q      <= e1_d;
    f1_q      <= mant[FRAC_BITS-1:0];
    e2_q      <= e1_q;
    idx2_q    <= idx2_d;
    rem2_q    <= pos[FRAC_BITS-1:0];
    e3_q      <= e2_q;
    lo3_q     <= RomLo[idx2_q];
    diff3_q   <= RomHi[idx2_q] - RomLo[idx2_q];
    rem3_q    <= rem2_q;
    e4_q      <= e3_q;
    lo4_q     <= lo3_q;
    interp4_q <= prod[PRD_W-1:FRAC_BITS];
    ln5_q     <= $signed(ln_sum) - LN_W'(LN10000_Q16);
  end

  assign valid_o = valid_q[4];
  assign ln_o    = ln5_q;
  assign tag_o   = tag_q[4];

endmodule

@@ sv/dew_point_magnus.sv @@
// dew_point_magnus: top level of the Magnus dew point pipeline.
// Depends on dpm_pkg, dpm_div and dpm_ln.
//
// Usage: drive in_i (temperature, humidity) and raise start_i for one cycle
// per item; an item is taken at each rising edge with start_i high and
// busy_o low. busy_o is always low, so one item can enter every cycle.
// Each result appears on res_o for exactly one cycle with done_o high, in
// order of entry, after 45 register stages, the first loaded at the edge
// that took its item. These are the stages of the two pipelined dividers
// (18 and 14 quotient bit stages), the five-stage log unit and eight stages
// of input, scaling and clamping logic. Throughput is one item per cycle.
// Out-of-range inputs give valid_res = 0 and a zero dew point.
// Reset clears all valid bits, so nothing is delivered from items in flight
// at reset. The receiver cannot stall; results are not held.
module dew_point_magnus
  import dpm_pkg::*;
#(
  parameter int LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dpm_in_t  in_i,
  output logic     busy_o,
  output logic     done_o,
  output dpm_res_t res_o
);

  localparam int NUM1_W = 40;
  localparam int DEN1_W = 22;
  localparam int Q1_W   = 18;
  localparam int NUM2_W = 41;
  localparam int DEN2_W = 28;
  localparam int Q2_W   = 14;
  localparam int TM_W   = 26;
  localparam int T1_W   = Q1_W + 1;
  localparam int P2_W   = 44;
  localparam int TD_W   = Q2_W + 1;

  typedef struct packed {
    logic signed [TEMP_W-1:0] t;
    logic [HUM_W-1:0]         h;
    logic                     bad;
    logic                     sat;
    logic                     neg;
  } tag1_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] t;
    logic                     bad;
    logic                     sat;
    logic signed [T1_W-1:0]   term1;
  } tagl_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] t;
    logic                     bad;
    logic                     sat;
    logic                     neg;
  } tag2_t;

  assign busy_o = 1'b0;

  // stage a: input register
  logic    a_valid_q;
  dpm_in_t a_in_q;

  // stage b: range checks, 1727*t and first divisor
  logic                     b_valid_q;
  logic signed [TEMP_W-1:0] b_t_q;
  logic [HUM_W-1:0]         b_h_q;
  logic                     b_bad_q;
  logic                     b_sat_q;
  logic signed [TM_W-1:0]   b_tm_q;
  logic [DEN1_W-1:0]        b_d1_q;
  logic signed [15:0]       tsum;

  assign tsum = 16'(a_in_q.temperature) + 16'sd23770;

  // stage c: rounded magnitude for the first division
  logic              c_valid_q;
  tag1_t             c_tag_q;
  logic [NUM1_W-1:0] c_n1_q;
  logic [DEN1_W-1:0] c_d1_q;
  logic [TM_W-1:0]   tm_mag;

  assign tm_mag = b_tm_q[TM_W-1] ? TM_W'(-b_tm_q) : TM_W'(b_tm_q);

  logic              d1_valid;
  logic [Q1_W-1:0]   d1_quo;
  logic [$bits(tag1_t)-1:0] d1_tag_vec;
  tag1_t             d1_tag;

  dpm_div #(
    .NUM_W(NUM1_W), .DEN_W(DEN1_W), .Q_W(Q1_W), .TAG_W($bits(tag1_t))
  ) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid_q),
    .num_i   (c_n1_q),
    .den_i   (c_d1_q),
    .tag_i   (c_tag_q),
    .valid_o (d1_valid),
    .quo_o   (d1_quo),
    .tag_o   (d1_tag_vec)
  );

  assign d1_tag = tag1_t'(d1_tag_vec);

  // stage d: signed first term
  logic            dd_valid_q;
  logic [HUM_W-1:0] dd_h_q;
  tagl_t           dd_tag_q;
  logic signed [T1_W-1:0] term1;

  assign term1 = d1_tag.neg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});

  logic                     ln_valid;
  logic signed [LN_W-1:0]   ln_val;
  logic [$bits(tagl_t)-1:0] ln_tag_vec;
  tagl_t                    ln_tag;

  dpm_ln #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES), .TAG_W($bits(tagl_t))
  ) u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dd_valid_q),
    .hum_i   (dd_h_q),
    .tag_i   (dd_tag_q),
    .valid_o (ln_valid),
    .ln_o    (ln_val),
    .tag_o   (ln_tag_vec)
  );

  assign ln_tag = tagl_t'(ln_tag_vec);

  // stage e: alpha
  logic                   e_valid_q;
  tag2_t                  e_tag_q;
  logic signed [LN_W-1:0] e_al_q;

  // stage f: second numerator and divisor
  logic                   f_valid_q;
  tag2_t                  f_tag_q;
  logic signed [P2_W-1:0] f_num_q;
  logic [DEN2_W-1:0]      f_den_q;
  logic signed [28:0]     al100;
  logic signed [28:0]     den2;

  always_comb begin
    al100 = 29'(e_al_q) * 29'sd100;
    den2  = 29'sd113180672 - al100;
  end

  // stage g: rounded magnitude for the second division
  logic              g_valid_q;
  tag2_t             g_tag_q;
  logic [NUM2_W-1:0] g_n2_q;
  logic [DEN2_W-1:0] g_d2_q;
  logic [P2_W-1:0]   num_mag;

  assign num_mag = f_num_q[P2_W-1] ? P2_W'(-f_num_q) : P2_W'(f_num_q);

  logic                     d2_valid;
  logic [Q2_W-1:0]          d2_quo;
  logic [$bits(tag2_t)-1:0] d2_tag_vec;
  tag2_t                    d2_tag;

  dpm_div #(
    .NUM_W(NUM2_W), .DEN_W(DEN2_W), .Q_W(Q2_W), .TAG_W($bits(tag2_t))
  ) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_valid_q),
    .num_i   (g_n2_q),
    .den_i   (g_d2_q),
    .tag_i   (g_tag_q),
    .valid_o (d2_valid),
    .quo_o   (d2_quo),
    .tag_o   (d2_tag_vec)
  );

  assign d2_tag = tag2_t'(d2_tag_vec);

  // stage h: sign, limit to air temperature, clamp
  logic signed [TD_W-1:0] td;
  logic signed [TD_W-1:0] t_ext;
  logic signed [TD_W-1:0] td_lim;
  dpm_res_t               res_d;

  always_comb begin
    td     = d2_tag.neg ? -$signed({1'b0, d2_quo}) : $signed({1'b0, d2_quo});
    t_ext  = TD_W'(d2_tag.t);
    td_lim = td;
    if (td_lim > t_ext)             td_lim = t_ext;
    if (td_lim < TD_W'(T_MIN))      td_lim = TD_W'(T_MIN);
    if (td_lim > TD_W'(T_MAX))      td_lim = TD_W'(T_MAX);
    if (d2_tag.sat)                 td_lim = t_ext;
    res_d.dewpt     = TEMP_W'(td_lim);
    res_d.valid_res = 1'b1;
    if (d2_tag.bad) begin
      res_d.dewpt     = '0;
      res_d.valid_res = 1'b0;
    end
  end

  dpm_res_t h_res_q;
  logic     h_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
      c_valid_q  <= 1'b0;
      dd_valid_q <= 1'b0;
      e_valid_q  <= 1'b0;
      f_valid_q  <= 1'b0;
      g_valid_q  <= 1'b0;
      h_valid_q  <= 1'b0;
    end else begin
      a_valid_q  <= start_i && !busy_o;
      b_valid_q  <= a_valid_q;
      c_valid_q  <= b_valid_q;
      dd_valid_q <= d1_valid;
      e_valid_q  <= ln_valid;
      f_valid_q  <= e_valid_q;
      g_valid_q  <= f_valid_q;
      h_valid_q  <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    a_in_q <= in_i;

    b_t_q   <= a_in_q.temperature;
    b_h_q   <= a_in_q.humidity;
    b_bad_q <= (a_in_q.temperature < T_MIN) || (a_in_q.temperature > T_MAX) ||
               (a_in_q.humidity < H_MIN) || (a_in_q.humidity > H_MAX);
    b_sat_q <= (a_in_q.humidity >= H_MAX);
    b_tm_q  <= TM_W'(a_in_q.temperature) * TM_W'(1727);
    b_d1_q  <= DEN1_W'(tsum) * DEN1_W'(100);

    c_tag_q.t   <= b_t_q;
    c_tag_q.h   <= b_h_q;
    c_tag_q.bad <= b_bad_q;
    c_tag_q.sat <= b_sat_q;
    c_tag_q.neg <= b_tm_q[TM_W-1];
    c_n1_q      <= NUM1_W'({tm_mag[23:0], 16'h0000}) + NUM1_W'(b_d1_q >> 1);
    c_d1_q      <= b_d1_q;

    dd_h_q         <= d1_tag.h;
    dd_tag_q.t     <= d1_tag.t;
    dd_tag_q.bad   <= d1_tag.bad;
    dd_tag_q.sat   <= d1_tag.sat;
    dd_tag_q.term1 <= term1;

    e_tag_q.t   <= ln_tag.t;
    e_tag_q.bad <= ln_tag.bad;
    e_tag_q.sat <= ln_tag.sat;
    e_tag_q.neg <= 1'b0;
    e_al_q      <= LN_W'(ln_tag.term1) + ln_val;

    f_tag_q <= e_tag_q;
    f_num_q <= P2_W'(e_al_q) * P2_W'(2377000);
    f_den_q <= DEN2_W'(den2);

    g_tag_q.t   <= f_tag_q.t;
    g_tag_q.bad <= f_tag_q.bad;
    g_tag_q.sat <= f_tag_q.sat;
    g_tag_q.neg <= f_num_q[P2_W-1];
    g_n2_q      <= NUM2_W'(num_mag) + NUM2_W'(f_den_q >> 1);
    g_d2_q      <= f_den_q;

    h_res_q <= res_d;
  end

  assign done_o = h_valid_q;
  assign res_o  = h_res_q;

endmodule

@@ dv/dew_point_magnus_tb.sv @@
// dew_point_magnus_tb: self-checking testbench for the Magnus dew point block.
// Depends on dpm_pkg and dew_point_magnus; holds its own dew point predictor.
module dew_point_magnus_tb
  import dpm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_LOG      = LOG_TABLE_ENTRIES_DEF;
  localparam int LATENCY    = 45;
  localparam int STALL_LIMIT = 2000;

  class dew_scoreboard;
    longint    ln_tab[N_LOG+1];
    dpm_res_t  pending[$];
    int        n_fail;
    int        n_checked;
    int        n_invalid;
    int        n_saturated;

    function new();
      longint unsigned z, z2, pw, sum;
      n_fail = 0;
      n_checked = 0;
      n_invalid = 0;
      n_saturated = 0;
      for (int i = 0; i <= N_LOG; i++) begin
        z = (longint'(i) << 30) / longint'(2 * N_LOG + i);
        z2 = (z * z) >> 30;
        pw = z;
        sum = 0;
        for (int k = 0; k < 25; k++) begin
          sum += pw / longint'(2 * k + 1);
          pw = (pw * z2) >> 30;
        end
        ln_tab[i] = longint'((2 * sum + 8192) >> 14);
      end
    endfunction

    function longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    // ln(h/10000) in Q16 through the interpolated table
    function longint ln_humidity(longint unsigned h);
      int e;
      longint unsigned f, pos, idx, rem;
      longint lo, hi;
      e = 13;
      while (e > 0 && h[e] == 1'b0) e--;
      f = ((h << FRAC_BITS) >> e) - (64'd1 << FRAC_BITS);
      pos = f * N_LOG;
      idx = pos >> FRAC_BITS;
      rem = pos & ((64'd1 << FRAC_BITS) - 1);
      if (idx >= N_LOG) idx = N_LOG - 1;
      lo = ln_tab[idx];
      hi = ln_tab[idx+1];
      lo = lo + longint'(((hi - lo) * rem + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      return longint'(e) * LN2_Q16 + lo - LN10000_Q16;
    endfunction

    function void note_item(dpm_in_t it);
      dpm_res_t r;
      longint t, h, alpha, td;
      t = longint'(it.temperature);
      h = longint'(it.humidity);
      r = '0;
      if (t < -4000 || t > 5000 || h < 10 || h > 10000) begin
        n_invalid++;
      end else begin
        if (h == 10000) begin
          td = t;
          n_saturated++;
        end else begin
          alpha = round_div(1727 * t * 65536, 100 * (23770 + t)) + ln_humidity(h);
          td = round_div(2377000 * alpha, 1727 * 64'sd65536 - 100 * alpha);
          if (td > t) td = t;
          if (td < -4000) td = -4000;
          if (td > 5000) td = 5000;
        end
        r.dewpt = td[TEMP_W-1:0];
        r.valid_res = 1'b1;
      end
      pending.push_back(r);
    endfunction

    function void check_result(dpm_res_t got);
      dpm_res_t want;
      if (pending.size() == 0) begin
        $error("result with no item pending: dewpt %0d valid_res %0b",
               got.dewpt, got.valid_res);
        n_fail++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.dewpt !== want.dewpt) begin
        $error("dewpt: expected %0d, got %0d", want.dewpt, got.dewpt);
        n_fail++;
      end
      if (got.valid_res !== want.valid_res) begin
        $error("valid_res: expected %0b, got %0b", want.valid_res, got.valid_res);
        n_fail++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  dpm_in_t  in_i;
  logic     busy_o;
  logic     done_o;
  dpm_res_t res_o;

  dew_scoreboard sb;
  int idle_pct;
  int quiet_cycles;

  dew_point_magnus dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (in_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // results checked and watchdog kept at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if (done_o || (start_i && !busy_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("dew_point_magnus_tb failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic signed [TEMP_W-1:0] t, logic [HUM_W-1:0] h);
    dpm_in_t it;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    it.temperature = t;
    it.humidity = h;
    start_i <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic signed [TEMP_W-1:0] t;
    logic [HUM_W-1:0] h;
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      t = 14'($signed($urandom_range(9000)) - 4000);
      if ($urandom_range(9) == 0) h = 14'($urandom_range(10000, 9900));
      else h = 14'($urandom_range(10000, 10));
    end else if (pick < 92) begin
      t = 14'($urandom);
      h = 14'($urandom);
    end else begin
      t = 14'($signed($urandom_range(9000)) - 4000);
      h = 14'($urandom_range(9));
    end
    send_item(t, h);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // limits, saturation, bad inputs and sign and bit extremes
    send_item(-14'sd4000, 14'd10);
    send_item(-14'sd4000, 14'd10000);
    send_item(14'sd5000, 14'd10);
    send_item(14'sd5000, 14'd10000);
    send_item(14'sd0, 14'd5000);
    send_item(14'sd2500, 14'd9999);
    send_item(-14'sd4001, 14'd5000);
    send_item(14'sd5001, 14'd5000);
    send_item(14'sd0, 14'd9);
    send_item(14'sd0, 14'd0);
    send_item(14'sd0, 14'd10001);
    send_item(14'sd1000, 14'h3fff);
    send_item(14'h1fff, 14'd5000);
    send_item(14'h2000, 14'd5000);
    send_item(-14'sd1, 14'd8192);
    send_item(14'sd3000, 14'd4096);
    send_item(14'sd3000, 14'd8191);
    send_item(-14'sd3999, 14'd11);
    send_item(14'sd4999, 14'd9998);
    send_item(14'sd2000, 14'd1024);
    wait_drained();

    idle_pct = 35;
    repeat (170) send_random();
    // hold off until the pipeline is empty
    wait_drained();
    idle_pct = 63;
    repeat (170) send_random();
    idle_pct = 0;
    repeat (170) send_random();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("checked %0d results: %0d with bad inputs, %0d at saturation",
             sb.n_checked, sb.n_invalid, sb.n_saturated);
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("dew_point_magnus_tb passed");
    end else begin
      $display("dew_point_magnus_tb failed");
    end
    $finish;
  end
endmodule
